[rtl/core/faai_pkg.sv]
// shared types and constants for the floating-point add/multiply unit
package faai_pkg;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_MUL = 2'd1,
        ACT_INC = 2'd2,
        ACT_RSV = 2'd3
    } action_t;

    localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] EXP_MASK    = 32'h7F80_0000;

    // stage 1 -> stage 2: unpacked operands, exact product or aligned sum
    typedef struct packed {
        logic        special;     // result already known
        logic [31:0] special_res;
        logic        sign;
        logic signed [10:0] exp;  // value = mag * 2^exp
        logic [57:0] mag;         // nonzero unless special
    } norm_t;

    // stage 2 -> stage 3: leading one position found
    typedef struct packed {
        logic        special;
        logic [31:0] special_res;
        logic        sign;
        logic signed [10:0] exp;
        logic [57:0] mag;
        logic [5:0]  lead;
    } lead_t;

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return x[30:0] == EXP_MASK[30:0];
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

endpackage

[rtl/core/float_alu_add_mul_inc_top.sv]
// top level of the floating-point add/multiply/increment unit
// Single-precision add, multiply and increment, round to nearest even, full
// subnormal support, SSE-style NaN handling. Three-stage pipeline: operand
// decode with alignment-add or 24x24 product, leading-one search, then round
// and pack. Each stage is registered, and one request can be taken every
// cycle unless the input is stalled. A stall on the output holds the last
// stage; an earlier stage takes a new request whenever it is empty or moving
// forward, so the input stalls only when all three stages are full and the
// output is stalled.
module float_alu_add_mul_inc_top
    import faai_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result,
    output logic        zero_flag,
    output logic        negative_flag
);

    norm_t       s1_next;
    norm_t       s1_reg;
    lead_t       s2_next;
    lead_t       s2_reg;
    logic [31:0] s3_next;
    logic [31:0] s3_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        en3;
    logic        en2;
    logic        en1;

    faai_front u_front (
        .action    (action),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .norm      (s1_next)
    );

    always_comb
    begin
        s2_next.special = s1_reg.special;
        s2_next.special_res = s1_reg.special_res;
        s2_next.sign = s1_reg.sign;
        s2_next.exp = s1_reg.exp;
        s2_next.mag = s1_reg.mag;
        s2_next.lead = 6'd0;
        for (int i = 0; i < 58; i++)
        begin
            if (s1_reg.mag[i])
                s2_next.lead = 6'(i);
        end
    end

    faai_round u_round (
        .ld  (s2_reg),
        .res (s3_next)
    );

    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
            s3_reg <= s3_next;
    end

    assign out_valid = v3_reg;
    assign result = s3_reg;
    assign zero_flag = is_zero(s3_reg);
    assign negative_flag = s3_reg[31] && !is_zero(s3_reg) && !is_nan(s3_reg);

endmodule

[rtl/core/faai_front.sv]
// stage 1: special cases, alignment and add, or the mantissa product
module faai_front
    import faai_pkg::*;
(
    input  logic [1:0]  action,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output norm_t       norm
);

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] x;
    logic [31:0] y;
    logic [23:0] mx;
    logic [23:0] my;
    logic [23:0] ma;
    logic [23:0] mb;
    logic signed [10:0] ex;
    logic signed [10:0] ey;
    logic signed [10:0] ea;
    logic signed [10:0] eb;
    logic [10:0] d;
    logic [57:0] wx;
    logic [57:0] wy;
    logic [57:0] wys;
    logic [57:0] lostmask;
    logic [57:0] msum;
    logic [47:0] prod;
    logic        is_mul;

    always_comb
    begin
        is_mul = (action_t'(action) == ACT_MUL);
        a = operand_a;
        b = (action_t'(action) == ACT_INC) ? ONE_BITS : operand_b;
        if (a[30:0] >= b[30:0])
        begin
            x = a;
            y = b;
        end
        else
        begin
            x = b;
            y = a;
        end
        mx = {(x[30:23] != 8'd0), x[22:0]};
        my = {(y[30:23] != 8'd0), y[22:0]};
        ex = (x[30:23] == 8'd0) ? -11'sd149 : $signed({3'd0, x[30:23]}) - 11'sd150;
        ey = (y[30:23] == 8'd0) ? -11'sd149 : $signed({3'd0, y[30:23]}) - 11'sd150;
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        ea = (a[30:23] == 8'd0) ? -11'sd149 : $signed({3'd0, a[30:23]}) - 11'sd150;
        eb = (b[30:23] == 8'd0) ? -11'sd149 : $signed({3'd0, b[30:23]}) - 11'sd150;
        prod = ma * mb;
        // alignment with sticky: magnitudes are shifted up 32 places
        d = 11'(ex - ey);
        wx = {2'd0, mx, 32'd0};
        wy = {2'd0, my, 32'd0};
        lostmask = (58'd1 << d[5:0]) - 58'd1;
        if (d >= 11'd58)
            wys = 58'd1;
        else
            wys = (wy >> d[5:0]) | {57'd0, ((wy & lostmask) != 58'd0)};
        msum = (x[31] == y[31]) ? wx + wys : wx - wys;

        norm.special = 1'b0;
        norm.special_res = 32'd0;
        norm.sign = x[31];
        norm.exp = ex - 11'sd32;
        norm.mag = msum;
        if (is_mul)
        begin
            norm.sign = a[31] ^ b[31];
            norm.exp = ea + eb;
            norm.mag = {10'd0, prod};
            if (is_nan(a))
            begin
                norm.special = 1'b1;
                norm.special_res = a | QUIET_BIT;
            end
            else if (is_nan(b))
            begin
                norm.special = 1'b1;
                norm.special_res = b | QUIET_BIT;
            end
            else if (is_inf(a) || is_inf(b))
            begin
                norm.special = 1'b1;
                norm.special_res = (is_zero(a) || is_zero(b)) ? DEFAULT_NAN
                                 : ({a[31] ^ b[31], 31'd0} | EXP_MASK);
            end
            else if (is_zero(a) || is_zero(b))
            begin
                norm.special = 1'b1;
                norm.special_res = {a[31] ^ b[31], 31'd0};
            end
        end
        else
        begin
            if (is_nan(a))
            begin
                norm.special = 1'b1;
                norm.special_res = a | QUIET_BIT;
            end
            else if (is_nan(b))
            begin
                norm.special = 1'b1;
                norm.special_res = b | QUIET_BIT;
            end
            else if (is_inf(a))
            begin
                norm.special = 1'b1;
                norm.special_res = (is_inf(b) && (a[31] != b[31])) ? DEFAULT_NAN : a;
            end
            else if (is_inf(b))
            begin
                norm.special = 1'b1;
                norm.special_res = b;
            end
            else if (is_zero(a) && is_zero(b))
            begin
                norm.special = 1'b1;
                norm.special_res = {a[31] & b[31], 31'd0};
            end
            else if (is_zero(a))
            begin
                norm.special = 1'b1;
                norm.special_res = b;
            end
            else if (is_zero(b))
            begin
                norm.special = 1'b1;
                norm.special_res = a;
            end
            else if (msum == 58'd0)
            begin
                norm.special = 1'b1;
                norm.special_res = 32'd0;
            end
        end
    end

endmodule

[rtl/core/faai_round.sv]
// stage 3: shift, round to nearest even and pack
module faai_round
    import faai_pkg::*;
(
    input  lead_t       ld,
    output logic [31:0] res
);

    logic signed [11:0] shift;
    logic signed [11:0] alt;
    logic [5:0]  sh;
    logic [57:0] rem;
    logic [57:0] half;
    logic [57:0] q;
    logic [24:0] qr;
    logic signed [11:0] e2;
    logic signed [11:0] be;

    always_comb
    begin
        shift = $signed({6'd0, ld.lead}) - 12'sd23;
        alt = -12'sd149 - 12'(ld.exp);
        if (alt > shift)
            shift = alt;
        if (shift > 12'sd57)
            shift = 12'sd57;
        rem = 58'd0;
        half = 58'd0;
        if (shift <= 12'sd0)
        begin
            sh = 6'(-shift);
            q = ld.mag << sh;
            qr = q[24:0];
        end
        else
        begin
            sh = shift[5:0];
            rem = ld.mag & ((58'd1 << sh) - 58'd1);
            half = 58'd1 << (sh - 6'd1);
            q = ld.mag >> sh;
            qr = q[24:0] + {24'd0, ((rem > half) || ((rem == half) && q[0]))};
        end
        e2 = 12'(ld.exp) + shift;
        if (qr[24])
        begin
            qr = qr >> 1;
            e2 = e2 + 12'sd1;
        end
        be = e2 + 12'sd150;
        if (ld.special)
            res = ld.special_res;
        else if (qr[23])
            res = (be >= 12'sd255) ? ({ld.sign, 31'd0} | EXP_MASK)
                                   : {ld.sign, be[7:0], qr[22:0]};
        else
            res = {ld.sign, 8'd0, qr[22:0]};
    end

endmodule

[rtl/core/faai_checker.sv]
// port-level checks for the floating-point unit, bound to the top level
module faai_checker
    import faai_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result,
    input logic        zero_flag,
    input logic        negative_flag
);

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(zero_flag && negative_flag))
        else $error("zero and negative flags both set");

    a_zero_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (zero_flag == (result[30:0] == 31'd0)))
        else $error("zero flag disagrees with result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result)))
        else $error("stalled result changed");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output stage");

endmodule

bind float_alu_add_mul_inc_top faai_checker u_faai_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result        (result),
    .zero_flag     (zero_flag),
    .negative_flag (negative_flag)
);
